// ===== rtl/gme_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the group mailbox engine.
package gme_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;

  localparam logic [FUNC_W-1:0] FN_SEND  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RECV  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_COUNT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_BLOCK = 3'd3;
  localparam logic [FUNC_W-1:0] FN_JOIN  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_LEAVE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOMSG     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BLOCKFULL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_GROUPFULL = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BLK_RD,
    S_BLK_CHK,
    S_BC_NEXT,
    S_PUSH,
    S_MSG_RD,
    S_MSG_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LEAVE_RD,
    S_LEAVE_WR,
    S_DONE
  } state_t;

endpackage

// ===== rtl/group_mailbox_engine_top.sv =====
`timescale 1ns / 1ps
// Group mailbox engine: message buffer and block lists held in synchronous memories.
// One request at a time: busy is high from acceptance through the result strobe, so the next
// request is accepted at the earliest in the cycle after the strobe. Block, join and refusals
// found at decode go straight to the strobe; unicast send reads and checks each block entry
// of a member receiver, then pushes; broadcast repeats that for every member but the sender;
// receive and count read and check each slot, and receive then moves the later slots down;
// leave moves the block rows down. Reset clears the state machine and counts, not the memories.
module group_mailbox_engine_top #(
  parameter int BUFFER_DEPTH = 16,
  parameter int MEMBER_SLOTS = 8,
  parameter int BLOCK_SLOTS  = 8,
  parameter int PID_WIDTH    = 8,
  parameter int TEXT_WIDTH   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [gme_pkg::FUNC_W-1:0]           in_func,
  input  logic [PID_WIDTH-1:0]                 in_caller_pid,
  input  logic [PID_WIDTH-1:0]                 in_from_pid,
  input  logic [PID_WIDTH-1:0]                 in_to_pid,
  input  logic                                 in_broadcast,
  input  logic [TEXT_WIDTH-1:0]                in_payload,
  input  logic [PID_WIDTH-1:0]                 in_target_pid,
  output logic                                 out_valid,
  output logic [gme_pkg::STATUS_W-1:0]         out_status,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0]    out_count,
  output logic [PID_WIDTH-1:0]                 out_msg_from,
  output logic [PID_WIDTH-1:0]                 out_msg_to,
  output logic [TEXT_WIDTH-1:0]                out_msg_payload
);

  localparam int CW    = $clog2(BUFFER_DEPTH + 1);
  localparam int BAW   = $clog2(BUFFER_DEPTH);
  localparam int MIW   = $clog2(MEMBER_SLOTS);
  localparam int MTW   = $clog2(MEMBER_SLOTS + 1);
  localparam int BTW   = $clog2(BLOCK_SLOTS + 1);
  localparam int BKD   = MEMBER_SLOTS * BLOCK_SLOTS;
  localparam int BKAW  = $clog2(BKD);
  localparam int BKCW  = $clog2(BKD + 1);
  localparam int MSGW  = 2 * PID_WIDTH + TEXT_WIDTH;

  gme_pkg::state_t state_r, state_nxt;

  logic [gme_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [PID_WIDTH-1:0]       caller_r, caller_nxt;
  logic [PID_WIDTH-1:0]       from_r, from_nxt;
  logic [PID_WIDTH-1:0]       to_r, to_nxt;
  logic                       bcast_r, bcast_nxt;
  logic [TEXT_WIDTH-1:0]      text_r, text_nxt;
  logic [PID_WIDTH-1:0]       target_r, target_nxt;

  logic [CW-1:0]              occ_r, occ_nxt;
  logic [MTW-1:0]             mtotal_r, mtotal_nxt;
  logic [PID_WIDTH-1:0]       member_r [MEMBER_SLOTS];
  logic [PID_WIDTH-1:0]       member_nxt [MEMBER_SLOTS];
  logic [BTW-1:0]             btotal_r [MEMBER_SLOTS];
  logic [BTW-1:0]             btotal_nxt [MEMBER_SLOTS];

  logic [MTW-1:0]             i_r, i_nxt;
  logic [MIW-1:0]             tpos_r, tpos_nxt;
  logic [BTW-1:0]             k_r, k_nxt;
  logic [CW-1:0]              j_r, j_nxt;
  logic [BKCW-1:0]            a_r, a_nxt;
  logic [BKCW-1:0]            lim_r, lim_nxt;
  logic [PID_WIDTH-1:0]       rcpt_r, rcpt_nxt;

  logic [gme_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [PID_WIDTH-1:0]         mfrom_r, mfrom_nxt;
  logic [PID_WIDTH-1:0]         mto_r, mto_nxt;
  logic [TEXT_WIDTH-1:0]        mtext_r, mtext_nxt;

  // Message buffer memory: {sender, receiver, text}, oldest first.
  logic [MSGW-1:0]      msg_mem [BUFFER_DEPTH];
  logic                 msg_we, msg_re;
  logic [BAW-1:0]       msg_waddr, msg_raddr;
  logic [MSGW-1:0]      msg_wdata, msg_rdata_r;

  // Block list memory: row per member slot, BLOCK_SLOTS entries a row.
  logic [PID_WIDTH-1:0] blk_mem [BKD];
  logic                 blk_we, blk_re;
  logic [BKAW-1:0]      blk_waddr, blk_raddr;
  logic [PID_WIDTH-1:0] blk_wdata, blk_rdata_r;

  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_waddr] <= msg_wdata;
    end
    if (msg_re) begin
      msg_rdata_r <= msg_mem[msg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (blk_re) begin
      blk_rdata_r <= blk_mem[blk_raddr];
    end
  end

  // Member lookup over the live slots; the lowest matching slot wins.
  function automatic logic [MIW:0] find_slot(input logic [PID_WIDTH-1:0] key);
    logic [MIW:0] res;
    res = '0;
    for (int s = MEMBER_SLOTS - 1; s >= 0; s--) begin
      if (MTW'(s) < mtotal_r && member_r[s] == key) begin
        res = {1'b1, MIW'(s)};
      end
    end
    return res;
  endfunction

  logic [MIW:0]   caller_lk, to_lk;
  logic           caller_hit, to_hit;
  logic [MIW-1:0] caller_pos, to_pos;
  logic           blk_end, blk_match, bc_end, bc_self, occ_full;
  logic           msg_end, msg_match, shift_end, leave_end;
  logic [CW-1:0]  j_inc;
  logic [BKCW-1:0] blk_scan_addr, blk_add_addr, leave_src;

  // The lookup also depends on the member table, so it is evaluated procedurally.
  always_comb begin
    caller_lk = find_slot(caller_r);
    to_lk     = find_slot(to_r);
  end

  assign caller_hit = caller_lk[MIW];
  assign caller_pos = caller_lk[MIW-1:0];
  assign to_hit     = to_lk[MIW];
  assign to_pos     = to_lk[MIW-1:0];

  assign blk_end       = (k_r == btotal_r[tpos_r]);
  assign blk_match     = (blk_rdata_r == caller_r);
  assign bc_end        = (i_r == mtotal_r);
  assign bc_self       = (member_r[i_r[MIW-1:0]] == caller_r);
  assign occ_full      = (occ_r >= CW'(BUFFER_DEPTH));
  assign msg_end       = (j_r == occ_r);
  assign msg_match     = (msg_rdata_r[TEXT_WIDTH +: PID_WIDTH] == caller_r);
  assign j_inc         = j_r + CW'(1);
  assign shift_end     = (j_inc >= occ_r);
  assign leave_end     = (a_r >= lim_r);
  assign blk_scan_addr = BKCW'(tpos_r) * BKCW'(BLOCK_SLOTS) + BKCW'(k_r);
  assign blk_add_addr  = BKCW'(caller_pos) * BKCW'(BLOCK_SLOTS)
                         + BKCW'(btotal_r[caller_pos]);
  assign leave_src     = a_r + BKCW'(BLOCK_SLOTS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gme_pkg::S_IDLE: begin
        if (start) state_nxt = gme_pkg::S_DECODE;
      end
      gme_pkg::S_DECODE: begin
        case (func_r)
          gme_pkg::FN_SEND: begin
            if (from_r != caller_r || !caller_hit) state_nxt = gme_pkg::S_DONE;
            else if (bcast_r)                      state_nxt = gme_pkg::S_BC_NEXT;
            else if (to_hit)                       state_nxt = gme_pkg::S_BLK_RD;
            else                                   state_nxt = gme_pkg::S_PUSH;
          end
          gme_pkg::FN_RECV:  state_nxt = caller_hit ? gme_pkg::S_MSG_RD : gme_pkg::S_DONE;
          gme_pkg::FN_COUNT: state_nxt = gme_pkg::S_MSG_RD;
          gme_pkg::FN_LEAVE: state_nxt = caller_hit ? gme_pkg::S_LEAVE_RD : gme_pkg::S_DONE;
          default:           state_nxt = gme_pkg::S_DONE;
        endcase
      end
      gme_pkg::S_BLK_RD:  state_nxt = blk_end ? gme_pkg::S_PUSH : gme_pkg::S_BLK_CHK;
      gme_pkg::S_BLK_CHK: begin
        if (blk_match) state_nxt = bcast_r ? gme_pkg::S_BC_NEXT : gme_pkg::S_DONE;
        else           state_nxt = gme_pkg::S_BLK_RD;
      end
      gme_pkg::S_BC_NEXT: begin
        if (bc_end)       state_nxt = gme_pkg::S_DONE;
        else if (!bc_self) state_nxt = gme_pkg::S_BLK_RD;
      end
      gme_pkg::S_PUSH: begin
        if (occ_full || !bcast_r) state_nxt = gme_pkg::S_DONE;
        else                      state_nxt = gme_pkg::S_BC_NEXT;
      end
      gme_pkg::S_MSG_RD:  state_nxt = msg_end ? gme_pkg::S_DONE : gme_pkg::S_MSG_CHK;
      gme_pkg::S_MSG_CHK: begin
        if (msg_match && func_r == gme_pkg::FN_RECV) state_nxt = gme_pkg::S_SHIFT_RD;
        else                                         state_nxt = gme_pkg::S_MSG_RD;
      end
      gme_pkg::S_SHIFT_RD: state_nxt = shift_end ? gme_pkg::S_DONE : gme_pkg::S_SHIFT_WR;
      gme_pkg::S_SHIFT_WR: state_nxt = gme_pkg::S_SHIFT_RD;
      gme_pkg::S_LEAVE_RD: state_nxt = leave_end ? gme_pkg::S_DONE : gme_pkg::S_LEAVE_WR;
      gme_pkg::S_LEAVE_WR: state_nxt = gme_pkg::S_LEAVE_RD;
      gme_pkg::S_DONE:     state_nxt = gme_pkg::S_IDLE;
      default:             state_nxt = gme_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result fields.
  always_comb begin
    func_nxt   = func_r;
    caller_nxt = caller_r;
    from_nxt   = from_r;
    to_nxt     = to_r;
    bcast_nxt  = bcast_r;
    text_nxt   = text_r;
    target_nxt = target_r;
    occ_nxt    = occ_r;
    mtotal_nxt = mtotal_r;
    member_nxt = member_r;
    btotal_nxt = btotal_r;
    i_nxt      = i_r;
    tpos_nxt   = tpos_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    a_nxt      = a_r;
    lim_nxt    = lim_r;
    rcpt_nxt   = rcpt_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    mfrom_nxt  = mfrom_r;
    mto_nxt    = mto_r;
    mtext_nxt  = mtext_r;
    msg_we     = 1'b0;
    msg_re     = 1'b0;
    msg_waddr  = occ_r[BAW-1:0];
    msg_raddr  = j_r[BAW-1:0];
    msg_wdata  = {caller_r, rcpt_r, text_r};
    blk_we     = 1'b0;
    blk_re     = 1'b0;
    blk_waddr  = blk_add_addr[BKAW-1:0];
    blk_raddr  = blk_scan_addr[BKAW-1:0];
    blk_wdata  = target_r;

    case (state_r)
      gme_pkg::S_IDLE: begin
        if (start) begin
          func_nxt   = in_func;
          caller_nxt = in_caller_pid;
          from_nxt   = in_from_pid;
          to_nxt     = in_to_pid;
          bcast_nxt  = in_broadcast;
          text_nxt   = in_payload;
          target_nxt = in_target_pid;
          status_nxt = gme_pkg::ST_OK;
          count_nxt  = '0;
          mfrom_nxt  = '0;
          mto_nxt    = '0;
          mtext_nxt  = '0;
        end
      end
      gme_pkg::S_DECODE: begin
        case (func_r)
          gme_pkg::FN_SEND: begin
            if (from_r != caller_r || !caller_hit) begin
              status_nxt = gme_pkg::ST_INVALID;
            end else if (bcast_r) begin
              i_nxt = '0;
            end else begin
              tpos_nxt = to_pos;
              k_nxt    = '0;
              rcpt_nxt = to_r;
            end
          end
          gme_pkg::FN_RECV: begin
            if (!caller_hit) status_nxt = gme_pkg::ST_INVALID;
            j_nxt = '0;
          end
          gme_pkg::FN_COUNT: begin
            j_nxt = '0;
          end
          gme_pkg::FN_BLOCK: begin
            if (!caller_hit) begin
              status_nxt = gme_pkg::ST_INVALID;
            end else if (btotal_r[caller_pos] >= BTW'(BLOCK_SLOTS)) begin
              status_nxt = gme_pkg::ST_BLOCKFULL;
            end else begin
              blk_we                 = 1'b1;
              btotal_nxt[caller_pos] = btotal_r[caller_pos] + BTW'(1);
            end
          end
          gme_pkg::FN_JOIN: begin
            if (caller_hit) begin
              status_nxt = gme_pkg::ST_INVALID;
            end else if (mtotal_r >= MTW'(MEMBER_SLOTS)) begin
              status_nxt = gme_pkg::ST_GROUPFULL;
            end else begin
              member_nxt[mtotal_r[MIW-1:0]] = caller_r;
              btotal_nxt[mtotal_r[MIW-1:0]] = '0;
              mtotal_nxt = mtotal_r + MTW'(1);
            end
          end
          gme_pkg::FN_LEAVE: begin
            if (!caller_hit) begin
              status_nxt = gme_pkg::ST_INVALID;
            end else begin
              // Members after the leaver move down one slot; their block rows follow.
              for (int s = 0; s < MEMBER_SLOTS - 1; s++) begin
                if (MIW'(s) >= caller_pos && MTW'(s + 1) < mtotal_r) begin
                  member_nxt[s] = member_r[s + 1];
                  btotal_nxt[s] = btotal_r[s + 1];
                end
              end
              btotal_nxt[MIW'(mtotal_r - MTW'(1))] = '0;
              mtotal_nxt = mtotal_r - MTW'(1);
              a_nxt      = BKCW'(caller_pos) * BKCW'(BLOCK_SLOTS);
              lim_nxt    = BKCW'(mtotal_r - MTW'(1)) * BKCW'(BLOCK_SLOTS);
            end
          end
          default: begin
            status_nxt = gme_pkg::ST_INVALID;
          end
        endcase
      end
      gme_pkg::S_BLK_RD: begin
        blk_re = !blk_end;
      end
      gme_pkg::S_BLK_CHK: begin
        if (blk_match) begin
          if (bcast_r) i_nxt = i_r + MTW'(1);
          else         status_nxt = gme_pkg::ST_INVALID;
        end else begin
          k_nxt = k_r + BTW'(1);
        end
      end
      gme_pkg::S_BC_NEXT: begin
        if (!bc_end) begin
          if (bc_self) begin
            i_nxt = i_r + MTW'(1);
          end else begin
            tpos_nxt = i_r[MIW-1:0];
            k_nxt    = '0;
            rcpt_nxt = member_r[i_r[MIW-1:0]];
          end
        end
      end
      gme_pkg::S_PUSH: begin
        if (occ_full) begin
          status_nxt = gme_pkg::ST_FULL;
        end else begin
          msg_we    = 1'b1;
          occ_nxt   = occ_r + CW'(1);
          count_nxt = count_r + CW'(1);
          i_nxt     = i_r + MTW'(1);
        end
      end
      gme_pkg::S_MSG_RD: begin
        if (msg_end) begin
          if (func_r == gme_pkg::FN_RECV) status_nxt = gme_pkg::ST_NOMSG;
        end else begin
          msg_re = 1'b1;
        end
      end
      gme_pkg::S_MSG_CHK: begin
        if (msg_match && func_r == gme_pkg::FN_RECV) begin
          mfrom_nxt = msg_rdata_r[TEXT_WIDTH + PID_WIDTH +: PID_WIDTH];
          mto_nxt   = msg_rdata_r[TEXT_WIDTH +: PID_WIDTH];
          mtext_nxt = msg_rdata_r[TEXT_WIDTH-1:0];
        end else begin
          if (msg_match) count_nxt = count_r + CW'(1);
          j_nxt = j_inc;
        end
      end
      gme_pkg::S_SHIFT_RD: begin
        if (shift_end) begin
          occ_nxt = occ_r - CW'(1);
        end else begin
          msg_re    = 1'b1;
          msg_raddr = j_inc[BAW-1:0];
        end
      end
      gme_pkg::S_SHIFT_WR: begin
        msg_we    = 1'b1;
        msg_waddr = j_r[BAW-1:0];
        msg_wdata = msg_rdata_r;
        j_nxt     = j_inc;
      end
      gme_pkg::S_LEAVE_RD: begin
        blk_re    = !leave_end;
        blk_raddr = leave_src[BKAW-1:0];
      end
      gme_pkg::S_LEAVE_WR: begin
        blk_we    = 1'b1;
        blk_waddr = a_r[BKAW-1:0];
        blk_wdata = blk_rdata_r;
        a_nxt     = a_r + BKCW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gme_pkg::S_IDLE;
      occ_r    <= '0;
      mtotal_r <= '0;
      btotal_r <= '{default: '0};
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      mtotal_r <= mtotal_nxt;
      btotal_r <= btotal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    caller_r <= caller_nxt;
    from_r   <= from_nxt;
    to_r     <= to_nxt;
    bcast_r  <= bcast_nxt;
    text_r   <= text_nxt;
    target_r <= target_nxt;
    member_r <= member_nxt;
    i_r      <= i_nxt;
    tpos_r   <= tpos_nxt;
    k_r      <= k_nxt;
    j_r      <= j_nxt;
    a_r      <= a_nxt;
    lim_r    <= lim_nxt;
    rcpt_r   <= rcpt_nxt;
    status_r <= status_nxt;
    count_r  <= count_nxt;
    mfrom_r  <= mfrom_nxt;
    mto_r    <= mto_nxt;
    mtext_r  <= mtext_nxt;
  end

  assign busy            = (state_r != gme_pkg::S_IDLE);
  assign out_valid       = (state_r == gme_pkg::S_DONE);
  assign out_status      = status_r;
  assign out_count       = count_r;
  assign out_msg_from    = mfrom_r;
  assign out_msg_to      = mto_r;
  assign out_msg_payload = mtext_r;

endmodule

// ===== rtl/gme_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the group mailbox engine and their binding to the top level.
module gme_checker #(
  parameter int PID_WIDTH    = 8,
  parameter int TEXT_WIDTH   = 64,
  parameter int BUFFER_DEPTH = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [gme_pkg::STATUS_W-1:0]      out_status,
  input logic [$clog2(BUFFER_DEPTH+1)-1:0] out_count,
  input logic [PID_WIDTH-1:0]              out_msg_from,
  input logic [TEXT_WIDTH-1:0]             out_msg_payload
);

  // An accepted request keeps the engine busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("engine not busy after accepting a request");

  // A result closes the request: the strobe lasts one cycle and the engine is free after it.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  // A result only appears while a request is in flight.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe without a request");

  // Message fields are zero whenever a request fails.
  a_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gme_pkg::ST_OK |-> out_msg_from == '0 &&
      out_msg_payload == '0)
    else $error("message fields set on a failed request");

  // Refusals other than a full buffer push nothing.
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gme_pkg::ST_OK && out_status != gme_pkg::ST_FULL
      |-> out_count == '0)
    else $error("count set on a refused request");

endmodule

bind group_mailbox_engine_top gme_checker #(
  .PID_WIDTH(PID_WIDTH),
  .TEXT_WIDTH(TEXT_WIDTH),
  .BUFFER_DEPTH(BUFFER_DEPTH)
) u_gme_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_status(out_status),
  .out_count(out_count),
  .out_msg_from(out_msg_from),
  .out_msg_payload(out_msg_payload)
);
